// ===== hw/rtl/gdsu_pkg.sv =====
// Types, command codes and calendar tables for the Gregorian date step unit.
`timescale 1ns / 1ps

package gdsu_pkg;

    // Step commands; codes above CMD_NONE also leave the date unchanged
    localparam logic [2:0] CMD_NEXT_DAY   = 3'd0;
    localparam logic [2:0] CMD_PREV_DAY   = 3'd1;
    localparam logic [2:0] CMD_NEXT_MONTH = 3'd2;
    localparam logic [2:0] CMD_PREV_MONTH = 3'd3;
    localparam logic [2:0] CMD_NONE       = 3'd4;

    localparam logic [13:0] YEAR_MIN = 14'd1;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // Reciprocal multipliers: x/25 = (x*5243)>>17 for x < 16384, x/7 = (x*18725)>>17
    localparam logic [12:0] RECIP_25 = 13'd5243;
    localparam logic [14:0] RECIP_7  = 15'd18725;
    localparam int          RECIP_SH = 17;

    // Weekday codes that count as weekend
    localparam logic [2:0] WD_FRIDAY   = 3'd5;
    localparam logic [2:0] WD_SATURDAY = 3'd6;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
    } request_t;

    typedef struct packed {
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [2:0]  weekday;
        logic        is_weekend;
        logic        is_last_day;
        logic        date_valid;
        logic        year_overflow;
    } result_t;

    // Stepped date and flags carried down the weekday pipeline
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        last_day;
        logic        date_valid;
        logic        year_overflow;
    } step_t;

    // Length of a month; zero for a month code outside 1 to 12
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                4'd2:                                       len = leap ? 5'd29 : 5'd28;
                default:                                    len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // (31*mm)/12 with March counted as month 1 and January, February at the end
    function automatic logic [4:0] month_offset(input logic [3:0] m);
        logic [4:0] ofs;
        begin
            case (m)
                4'd1:    ofs = 5'd28;
                4'd2:    ofs = 5'd31;
                4'd3:    ofs = 5'd2;
                4'd4:    ofs = 5'd5;
                4'd5:    ofs = 5'd7;
                4'd6:    ofs = 5'd10;
                4'd7:    ofs = 5'd12;
                4'd8:    ofs = 5'd15;
                4'd9:    ofs = 5'd18;
                4'd10:   ofs = 5'd20;
                4'd11:   ofs = 5'd23;
                4'd12:   ofs = 5'd25;
                default: ofs = 5'd0;
            endcase
            return ofs;
        end
    endfunction

endpackage

// ===== hw/rtl/gregorian_date_step_unit.sv =====
// Gregorian date step unit: six-stage pipeline from request to stepped date and weekday.
// A request's valid bit passes through s1_vld_reg to s5_vld_reg and then done_reg, which drives done.
// Throughput: one request per cycle; busy is tied low, since no stage ever waits.
// Stages: year/25 multiply, date step, century multiply, weekday sum, mod-7 multiply, output.
// Reset clears every stage valid bit and done; payload registers are not reset.
// The receiver cannot stall: each result shows for one cycle with done high.
`timescale 1ns / 1ps

module gregorian_date_step_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gdsu_pkg::request_t  request,
    output logic                done,
    output gdsu_pkg::result_t   result
);

    // Stage valid bits
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, done_reg;

    // Stage 1: request and year/25
    gdsu_pkg::request_t s1_req_reg;
    logic [9:0]         s1_q25_reg;
    logic [26:0]        s1_prod;
    logic [9:0]         s1_q25_next;

    // Stage 2: stepped date
    gdsu_pkg::step_t s2_step_reg, s2_step_next;

    // Stage 3: shifted year, year/100, month offset
    gdsu_pkg::step_t s3_step_reg;
    logic [13:0]     s3_yy_reg, s3_yy_next;
    logic [7:0]      s3_q100_reg, s3_q100_next;
    logic [4:0]      s3_mofs_reg, s3_mofs_next;
    logic [24:0]     s3_prod;

    // Stage 4: weekday sum
    gdsu_pkg::step_t s4_step_reg;
    logic [13:0]     s4_sum_reg, s4_sum_next;

    // Stage 5: sum/7
    gdsu_pkg::step_t s5_step_reg;
    logic [13:0]     s5_sum_reg;
    logic [11:0]     s5_q7_reg, s5_q7_next;
    logic [28:0]     s5_prod;

    // Output
    gdsu_pkg::result_t result_reg, result_next;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // Valid bits advance every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            done_reg   <= s5_vld_reg;
        end
    end

    // Stage 1: divide the year by 25 through a reciprocal multiply
    always_comb
    begin
        s1_prod     = 27'(request.year_in) * 27'(gdsu_pkg::RECIP_25);
        s1_q25_next = s1_prod[26:gdsu_pkg::RECIP_SH];
    end

    // Stage 2: check the date and apply the command
    always_comb
    begin
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic        div4, div16, div25, leap;
        logic [4:0]  len, nlen;
        logic        valid, up_year, down_year, ovf;
        logic [13:0] ny;
        logic [3:0]  nm;
        logic [4:0]  nd;

        y     = s1_req_reg.year_in;
        m     = s1_req_reg.month_in;
        d     = s1_req_reg.day_in;
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        div25 = ((14'(s1_q25_reg) * 14'd25) == y);
        leap  = div4 && (!div25 || div16);
        len   = gdsu_pkg::month_days(m, leap);
        valid = (y >= gdsu_pkg::YEAR_MIN) && (y <= gdsu_pkg::YEAR_MAX) &&
                (d != 5'd0) && (d <= len);

        ny        = y;
        nm        = m;
        nd        = d;
        up_year   = 1'b0;
        down_year = 1'b0;
        nlen      = 5'd0;
        case (s1_req_reg.cmd)
            gdsu_pkg::CMD_NEXT_DAY:
            begin
                if (d == len)
                begin
                    nd = 5'd1;
                    if (m == 4'd12)
                    begin
                        ny      = y + 14'd1;
                        nm      = 4'd1;
                        up_year = 1'b1;
                    end
                    else
                        nm = m + 4'd1;
                end
                else
                    nd = d + 5'd1;
            end
            gdsu_pkg::CMD_PREV_DAY:
            begin
                if (d == 5'd1)
                begin
                    if (m == 4'd1)
                    begin
                        ny        = y - 14'd1;
                        nm        = 4'd12;
                        nd        = 5'd31;
                        down_year = 1'b1;
                    end
                    else
                    begin
                        nm = m - 4'd1;
                        nd = gdsu_pkg::month_days(nm, leap);
                    end
                end
                else
                    nd = d - 5'd1;
            end
            gdsu_pkg::CMD_NEXT_MONTH:
            begin
                if (m == 4'd12)
                begin
                    ny      = y + 14'd1;
                    nm      = 4'd1;
                    up_year = 1'b1;
                end
                else
                    nm = m + 4'd1;
                // February is only reached inside the same year, so leap of y holds
                nlen = gdsu_pkg::month_days(nm, leap);
                if (d > nlen)
                    nd = nlen;
            end
            gdsu_pkg::CMD_PREV_MONTH:
            begin
                if (m == 4'd1)
                begin
                    ny        = y - 14'd1;
                    nm        = 4'd12;
                    down_year = 1'b1;
                end
                else
                    nm = m - 4'd1;
                nlen = gdsu_pkg::month_days(nm, leap);
                if (d > nlen)
                    nd = nlen;
            end
            default:
            begin
                ny = y;
            end
        endcase

        // Drop the step when the date is invalid or the year would leave range
        ovf = valid && ((up_year && (y == gdsu_pkg::YEAR_MAX)) ||
                        (down_year && (y == gdsu_pkg::YEAR_MIN)));
        if (!valid || ovf)
        begin
            ny = y;
            nm = m;
            nd = d;
        end

        s2_step_next.year          = ny;
        s2_step_next.month         = nm;
        s2_step_next.day           = nd;
        s2_step_next.last_day      = valid && (nd == gdsu_pkg::month_days(nm, leap));
        s2_step_next.date_valid    = valid;
        s2_step_next.year_overflow = ovf;
    end

    // Stage 3: shift January and February into the prior year, divide by 100
    always_comb
    begin
        logic jan_feb;
        jan_feb      = (s2_step_reg.month <= 4'd2);
        s3_yy_next   = s2_step_reg.year - 14'(jan_feb);
        s3_prod      = 25'(s3_yy_next[13:2]) * 25'(gdsu_pkg::RECIP_25);
        s3_q100_next = s3_prod[24:gdsu_pkg::RECIP_SH];
        s3_mofs_next = gdsu_pkg::month_offset(s2_step_reg.month);
    end

    // Stage 4: add up the weekday terms
    always_comb
    begin
        logic [14:0] sum;
        sum = 15'(s3_step_reg.day) + 15'(s3_yy_reg) + 15'(s3_yy_reg[13:2])
            - 15'(s3_q100_reg) + 15'(s3_q100_reg[7:2]) + 15'(s3_mofs_reg);
        s4_sum_next = sum[13:0];
    end

    // Stage 5: divide the sum by 7 through a reciprocal multiply
    always_comb
    begin
        s5_prod    = 29'(s4_sum_reg) * 29'(gdsu_pkg::RECIP_7);
        s5_q7_next = s5_prod[28:gdsu_pkg::RECIP_SH];
    end

    // Output: remainder gives the weekday
    always_comb
    begin
        logic [13:0] rem;
        logic [2:0]  wd;
        rem = s5_sum_reg - (14'(s5_q7_reg) * 14'd7);
        wd  = s5_step_reg.date_valid ? rem[2:0] : 3'd0;

        result_next.year_out      = s5_step_reg.year;
        result_next.month_out     = s5_step_reg.month;
        result_next.day_out       = s5_step_reg.day;
        result_next.weekday       = wd;
        result_next.is_weekend    = (wd == gdsu_pkg::WD_FRIDAY) ||
                                    (wd == gdsu_pkg::WD_SATURDAY);
        result_next.is_last_day   = s5_step_reg.last_day;
        result_next.date_valid    = s5_step_reg.date_valid;
        result_next.year_overflow = s5_step_reg.year_overflow;
    end

    // Payload registers advance with their valid bits
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_req_reg <= request;
            s1_q25_reg <= s1_q25_next;
        end
        if (s1_vld_reg)
            s2_step_reg <= s2_step_next;
        if (s2_vld_reg)
        begin
            s3_step_reg <= s2_step_reg;
            s3_yy_reg   <= s3_yy_next;
            s3_q100_reg <= s3_q100_next;
            s3_mofs_reg <= s3_mofs_next;
        end
        if (s3_vld_reg)
        begin
            s4_step_reg <= s3_step_reg;
            s4_sum_reg  <= s4_sum_next;
        end
        if (s4_vld_reg)
        begin
            s5_step_reg <= s4_step_reg;
            s5_sum_reg  <= s4_sum_reg;
            s5_q7_reg   <= s5_q7_next;
        end
        if (s5_vld_reg)
            result_reg <= result_next;
    end

endmodule

// ===== tb/tb_gregorian_date_step_unit.sv =====
// Self-checking testbench for the Gregorian date step unit: directed and random date requests.
`timescale 1ns / 1ps

// Predicts each stepped date and matches results against requests in order
class date_scoreboard;
    gdsu_pkg::result_t expected_dates[$];
    int unsigned       mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    static function bit leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    static function int unsigned month_len(int unsigned y, int unsigned m);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    // Zeller-style weekday, with January and February counted in the prior year
    static function int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
        int unsigned a;
        int unsigned yy;
        int unsigned mm;
        a  = (m <= 2) ? 1 : 0;
        yy = y - a;
        mm = m + 12 * a - 2;
        return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    // Compute the stepped date and its flags for one request
    function gdsu_pkg::result_t step_date(gdsu_pkg::request_t r);
        gdsu_pkg::result_t res;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned ny;
        int unsigned nm;
        int unsigned nd;
        int unsigned len;
        int unsigned wd;
        bit          valid;
        bit          ovf;
        y  = r.year_in;
        m  = r.month_in;
        d  = r.day_in;
        ny = y;
        nm = m;
        nd = d;
        wd = 0;
        ovf = 1'b0;
        res = '0;
        valid = (y >= 1) && (y <= 9999) && (m >= 1) && (m <= 12) &&
                (d >= 1) && (d <= month_len(y, m));
        if (valid)
        begin
            len = month_len(y, m);
            case (r.cmd)
                gdsu_pkg::CMD_NEXT_DAY:
                begin
                    if (d == len)
                    begin
                        if (m == 12)
                        begin
                            ny = y + 1;
                            nm = 1;
                        end
                        else
                        begin
                            nm = m + 1;
                        end
                        nd = 1;
                    end
                    else
                    begin
                        nd = d + 1;
                    end
                end
                gdsu_pkg::CMD_PREV_DAY:
                begin
                    if (d == 1)
                    begin
                        if (m == 1)
                        begin
                            ny = y - 1;
                            nm = 12;
                            nd = 31;
                        end
                        else
                        begin
                            nm = m - 1;
                            nd = month_len(y, nm);
                        end
                    end
                    else
                    begin
                        nd = d - 1;
                    end
                end
                gdsu_pkg::CMD_NEXT_MONTH:
                begin
                    if (m == 12)
                    begin
                        ny = y + 1;
                        nm = 1;
                    end
                    else
                    begin
                        nm = m + 1;
                    end
                    if (nd > month_len(ny, nm)) nd = month_len(ny, nm);
                end
                gdsu_pkg::CMD_PREV_MONTH:
                begin
                    if (m == 1)
                    begin
                        ny = y - 1;
                        nm = 12;
                    end
                    else
                    begin
                        nm = m - 1;
                    end
                    if (nd > month_len(ny, nm)) nd = month_len(ny, nm);
                end
                default:
                begin
                end
            endcase
            // Hold the input date when the year would leave 1 to 9999
            if (ny < 1 || ny > 9999)
            begin
                ovf = 1'b1;
                ny  = y;
                nm  = m;
                nd  = d;
            end
            wd = day_of_week(ny, nm, nd);
            res.weekday     = 3'(wd);
            res.is_weekend  = (3'(wd) == gdsu_pkg::WD_FRIDAY) ||
                              (3'(wd) == gdsu_pkg::WD_SATURDAY);
            res.is_last_day = (nd == month_len(ny, nm));
        end
        res.year_out      = 14'(ny);
        res.month_out     = 4'(nm);
        res.day_out       = 5'(nd);
        res.date_valid    = valid;
        res.year_overflow = ovf;
        return res;
    endfunction

    function void note_request(gdsu_pkg::request_t r);
        expected_dates.insert(expected_dates.size(), step_date(r));
    endfunction

    static function string describe(gdsu_pkg::result_t r);
        return $sformatf("%0d-%0d-%0d wd=%0d we=%0d last=%0d valid=%0d ovf=%0d",
                         r.year_out, r.month_out, r.day_out, r.weekday, r.is_weekend,
                         r.is_last_day, r.date_valid, r.year_overflow);
    endfunction

    function void check_result(gdsu_pkg::result_t got);
        gdsu_pkg::result_t want;
        bit                bad;
        if (expected_dates.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: %s", describe(got));
            return;
        end
        want = expected_dates.pop_front();
        bad  = (got.year_out !== want.year_out) || (got.month_out !== want.month_out) ||
               (got.day_out !== want.day_out) || (got.weekday !== want.weekday) ||
               (got.is_weekend !== want.is_weekend) ||
               (got.is_last_day !== want.is_last_day) ||
               (got.date_valid !== want.date_valid) ||
               (got.year_overflow !== want.year_overflow);
        if (bad)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: expected %s, got %s", describe(want), describe(got));
        end
    endfunction

    function int unsigned pending();
        return expected_dates.size();
    endfunction
endclass

module tb_gregorian_date_step_unit;

    localparam int unsigned STALL_LIMIT = 500;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned RANDOM_ITEMS = 400;

    // Unassigned command codes, which act as no change
    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    gdsu_pkg::request_t request = '0;
    logic               done;
    gdsu_pkg::result_t  result;

    date_scoreboard sb;
    int unsigned    quiet_cycles = 0;
    bit             moved;

    gregorian_date_step_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Track accepted requests and results; stop on a long stall
    always @(posedge clk)
    begin
        moved = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_request(request);
                moved = 1'b1;
            end
            if (done)
            begin
                sb.check_result(result);
                moved = 1'b1;
            end
            if (moved)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(input gdsu_pkg::request_t r);
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // When allowed, drop start for a run of idle cycles, each drawn with a chance of 22 in a hundred
    task automatic maybe_idle(input bit allowed);
        while (allowed && $urandom_range(0, 99) < 22)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_date(input logic [2:0] c, input int unsigned y,
                             input int unsigned m, input int unsigned d);
        gdsu_pkg::request_t r;
        r.cmd      = c;
        r.year_in  = 14'(y);
        r.month_in = 4'(m);
        r.day_in   = 5'(d);
        maybe_idle(1'b1);
        send_request(r);
    endtask

    // Mostly valid dates near month and year edges, the rest raw noise
    function automatic gdsu_pkg::request_t random_request();
        gdsu_pkg::request_t r;
        int unsigned        y;
        int unsigned        m;
        int unsigned        len;
        int unsigned        d;
        if ($urandom_range(0, 99) < 25)
        begin
            r.cmd      = 3'($urandom);
            r.year_in  = 14'($urandom);
            r.month_in = 4'($urandom);
            r.day_in   = 5'($urandom);
            return r;
        end
        case ($urandom_range(0, 9))
            0:       y = $urandom_range(0, 1) ? 1 : 9999;
            1:       y = $urandom_range(1, 99) * 100;
            2:       y = $urandom_range(1, 2499) * 4;
            default: y = $urandom_range(1, 9999);
        endcase
        m   = $urandom_range(1, 12);
        len = sb.month_len(y, m);
        case ($urandom_range(0, 3))
            0:       d = 1;
            1:       d = len;
            2:       d = len - 1;
            default: d = $urandom_range(1, len);
        endcase
        r.cmd      = ($urandom_range(0, 9) == 0)
                   ? 3'($urandom_range(int'(gdsu_pkg::CMD_NONE), int'(CMD_RSVD_7)))
                   : 3'($urandom_range(int'(gdsu_pkg::CMD_NEXT_DAY),
                                       int'(gdsu_pkg::CMD_PREV_MONTH)));
        r.year_in  = 14'(y);
        r.month_in = 4'(m);
        r.day_in   = 5'(d);
        return r;
    endfunction

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Year range edges
        send_date(gdsu_pkg::CMD_PREV_DAY,   1,    1,  1);
        send_date(gdsu_pkg::CMD_PREV_MONTH, 1,    1,  15);
        send_date(gdsu_pkg::CMD_NEXT_DAY,   9999, 12, 31);
        send_date(gdsu_pkg::CMD_NEXT_MONTH, 9999, 12, 10);
        // Leap year rule and month ends
        send_date(gdsu_pkg::CMD_NEXT_DAY,   2024, 2,  28);
        send_date(gdsu_pkg::CMD_NEXT_DAY,   2024, 2,  29);
        send_date(gdsu_pkg::CMD_NEXT_DAY,   1900, 2,  28);
        send_date(gdsu_pkg::CMD_PREV_DAY,   2000, 3,  1);
        send_date(gdsu_pkg::CMD_NEXT_MONTH, 2023, 1,  31);
        send_date(gdsu_pkg::CMD_PREV_MONTH, 2024, 3,  31);
        send_date(gdsu_pkg::CMD_NEXT_DAY,   2023, 12, 31);
        send_date(gdsu_pkg::CMD_PREV_DAY,   2024, 1,  1);
        send_date(gdsu_pkg::CMD_PREV_DAY,   2023, 5,  1);
        // Invalid dates
        send_date(gdsu_pkg::CMD_NEXT_DAY,   0,     6,  10);
        send_date(gdsu_pkg::CMD_NEXT_DAY,   16383, 6,  10);
        send_date(gdsu_pkg::CMD_NEXT_DAY,   2023,  0,  10);
        send_date(gdsu_pkg::CMD_PREV_DAY,   2023,  15, 10);
        send_date(gdsu_pkg::CMD_NEXT_DAY,   2023,  4,  0);
        send_date(gdsu_pkg::CMD_NEXT_MONTH, 2023,  4,  31);
        send_date(gdsu_pkg::CMD_NEXT_DAY,   2023,  2,  29);
        send_date(gdsu_pkg::CMD_PREV_MONTH, 1900,  2,  29);
        // No-change and unknown commands
        send_date(gdsu_pkg::CMD_NONE,       2021,  7,  31);
        send_date(CMD_RSVD_5,               2021,  7,  4);
        send_date(CMD_RSVD_6,               9999,  12, 31);
        send_date(CMD_RSVD_7,               16383, 15, 31);

        // Let the pipeline drain completely once
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);

        // Random part, with a long stretch of back-to-back requests
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            maybe_idle(!(i >= 150 && i < 260));
            send_request(random_request());
        end
        start <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/gdsu_pkg.sv
hw/rtl/gregorian_date_step_unit.sv
tb/tb_gregorian_date_step_unit.sv
